// ===== rtl/qapm_pkg.sv =====
// ---------------------------------------------------------------------------
// qapm_pkg: shared constants and types for the attitude PID mixer
// Register indexes, fixed-point constants, queue status and entry sizing.
// ---------------------------------------------------------------------------
package qapm_pkg;

   // default widths handed to the top level
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int GAIN_WIDTH_DEF   = 16;

   // configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 48;
   localparam int GAIN_REG_W  = 48;
   localparam int BASE_W      = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_PITCH_GAINS = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ROLL_GAINS  = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_YAW_GAINS   = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_POWER  = 4'd3;

   localparam logic [BASE_W-1:0] BASE_POWER_RESET = 16'd35000;

   // integrator: 1/64 degree units, clamp at +-500 degrees
   localparam int INTEG_W     = 16;
   localparam int INTEG_LIMIT = 32000;

   // motor sums are kept at 2^-14 count
   localparam int OUT_SHIFT = 14;
   localparam int MOTOR_W   = 16;
   localparam int NUM_AXES  = 3;
   localparam int NUM_MOTORS = 4;

   // front-to-back queue
   localparam int QUEUE_DEPTH = 4;

   // level of the front-to-back queue, seen by both sides
   typedef struct packed {
      logic empty;
      logic full;
   } qapm_q_status_type;

   // one queue entry: three errors, three clamped integrals, three rates
   function automatic int entry_width(input int sw);
      return NUM_AXES * ((sw + 1) + INTEG_W + sw);
   endfunction

endpackage

// ===== rtl/quad_attitude_pid_mixer_core.sv =====
// ---------------------------------------------------------------------------
// quad_attitude_pid_mixer_core: attitude PID with X motor mixing
// Usage:
//   req_*  : one sensor sample per request (angles, rates, targets), taken
//            at a clock edge with req_valid high and req_stall low.
//   rsp_*  : four saturated motor PWM values, one response per request, in
//            order; held while rsp_stall is high.
//   csr_*  : register writes (index 0..2 packed P/I/D gains per axis,
//            index 3 base power); csr_ready is always high. Other indexes
//            are ignored. Write only while the block is idle.
//   Throughput: one request per cycle while req_stall is low. The integrator
//   add-and-clamp is combinational in the front; the three-stage multiply/mix
//   pipe in the back takes one entry per cycle unless a held response stalls it.
//   Receiver stall: the back pipe freezes, the 4-entry queue fills, and
//   req_stall rises once it is full (up to 7 requests in flight).
//   Reset: integrals and gains cleared, base power back to 35000, queue
//   and pipe emptied; no response is pending after reset.
// ---------------------------------------------------------------------------
module quad_attitude_pid_mixer_core
   import qapm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int GAIN_WIDTH   = GAIN_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [SAMPLE_WIDTH-1:0] req_pitch_angle,
   input  logic [SAMPLE_WIDTH-1:0] req_roll_angle,
   input  logic [SAMPLE_WIDTH-1:0] req_yaw_angle,
   input  logic [SAMPLE_WIDTH-1:0] req_pitch_rate,
   input  logic [SAMPLE_WIDTH-1:0] req_roll_rate,
   input  logic [SAMPLE_WIDTH-1:0] req_yaw_rate,
   input  logic [SAMPLE_WIDTH-1:0] req_target_pitch,
   input  logic [SAMPLE_WIDTH-1:0] req_target_roll,
   input  logic [SAMPLE_WIDTH-1:0] req_target_yaw,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [MOTOR_W-1:0]      rsp_motor_one,
   output logic [MOTOR_W-1:0]      rsp_motor_two,
   output logic [MOTOR_W-1:0]      rsp_motor_three,
   output logic [MOTOR_W-1:0]      rsp_motor_four,
   // register write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int ENTRY_W = entry_width(SAMPLE_WIDTH);

   // configuration registers
   logic [NUM_AXES-1:0][GAIN_REG_W-1:0] gains_ff, gains_in;
   logic [BASE_W-1:0]                   base_ff, base_in;

   assign csr_ready = 1'b1;

   always_comb begin
      gains_in = gains_ff;
      base_in  = base_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_PITCH_GAINS: gains_in[0] = csr_wdata[GAIN_REG_W-1:0];
            REG_ROLL_GAINS:  gains_in[1] = csr_wdata[GAIN_REG_W-1:0];
            REG_YAW_GAINS:   gains_in[2] = csr_wdata[GAIN_REG_W-1:0];
            REG_BASE_POWER:  base_in     = csr_wdata[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= '0;
         base_ff  <= BASE_POWER_RESET;
      end else begin
         gains_ff <= gains_in;
         base_ff  <= base_in;
      end
   end

   // front: intake and integrators
   qapm_q_status_type q_status;
   logic              req_accept;
   logic              q_pop;
   logic [ENTRY_W-1:0] q_wdata, q_rdata;
   logic [NUM_MOTORS-1:0][MOTOR_W-1:0] motor;

   assign req_stall  = q_status.full;
   assign req_accept = req_valid && !req_stall;

   qapm_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .ENTRY_W      (ENTRY_W)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .angle   ({req_yaw_angle, req_roll_angle, req_pitch_angle}),
      .rate    ({req_yaw_rate, req_roll_rate, req_pitch_rate}),
      .target  ({req_target_yaw, req_target_roll, req_target_pitch}),
      .q_wdata (q_wdata)
   );

   qapm_queue #(
      .ENTRY_W (ENTRY_W)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (req_accept),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   // back: products, axis sums, mixing
   qapm_back #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .GAIN_WIDTH   (GAIN_WIDTH),
      .ENTRY_W      (ENTRY_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_rdata    (q_rdata),
      .q_pop      (q_pop),
      .gains      (gains_ff),
      .base_power (base_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_motor  (motor)
   );

   assign rsp_motor_one   = motor[0];
   assign rsp_motor_two   = motor[1];
   assign rsp_motor_three = motor[2];
   assign rsp_motor_four  = motor[3];

endmodule

// ===== rtl/qapm_front.sv =====
// ---------------------------------------------------------------------------
// qapm_front: request intake and integrator
// Forms the per-axis error, updates the clamped integrals on every accepted
// request and packs error, integral and rate into one queue entry.
// ---------------------------------------------------------------------------
module qapm_front
   import qapm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int ENTRY_W      = entry_width(SAMPLE_WIDTH_DEF)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  logic [NUM_AXES-1:0][SAMPLE_WIDTH-1:0]  angle,
   input  logic [NUM_AXES-1:0][SAMPLE_WIDTH-1:0]  rate,
   input  logic [NUM_AXES-1:0][SAMPLE_WIDTH-1:0]  target,
   output logic [ENTRY_W-1:0]                     q_wdata
);

   localparam int EW  = SAMPLE_WIDTH + 1;
   localparam int SMW = ((EW > INTEG_W) ? EW : INTEG_W) + 1;
   localparam int INT_BASE  = NUM_AXES * EW;
   localparam int RATE_BASE = INT_BASE + NUM_AXES * INTEG_W;
   localparam logic signed [SMW-1:0] LIM_HI = SMW'(INTEG_LIMIT);
   localparam logic signed [SMW-1:0] LIM_LO = -LIM_HI;

   logic signed [INTEG_W-1:0] integ_ff [NUM_AXES];
   logic signed [INTEG_W-1:0] integ_in [NUM_AXES];
   logic signed [EW-1:0]      err      [NUM_AXES];
   logic signed [SMW-1:0]     sum      [NUM_AXES];

   // error, integral update with clamp, entry packing
   always_comb begin
      q_wdata = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
         err[a] = EW'(signed'(target[a])) - EW'(signed'(angle[a]));
         sum[a] = SMW'(integ_ff[a]) + SMW'(err[a]);
         if (sum[a] > LIM_HI) begin
            integ_in[a] = INTEG_W'(LIM_HI);
         end else if (sum[a] < LIM_LO) begin
            integ_in[a] = INTEG_W'(LIM_LO);
         end else begin
            integ_in[a] = INTEG_W'(sum[a]);
         end
         q_wdata[a*EW +: EW]                   = err[a];
         q_wdata[INT_BASE + a*INTEG_W +: INTEG_W] = integ_in[a];
         q_wdata[RATE_BASE + a*SAMPLE_WIDTH +: SAMPLE_WIDTH] = rate[a];
      end
   end

   // integrators advance only on accepted requests
   always_ff @(posedge clock) begin
      for (int a = 0; a < NUM_AXES; a++) begin
         if (reset) begin
            integ_ff[a] <= '0;
         end else if (accept) begin
            integ_ff[a] <= integ_in[a];
         end
      end
   end

endmodule

// ===== rtl/qapm_queue.sv =====
// ---------------------------------------------------------------------------
// qapm_queue: short FIFO between front and back
// Holds integrated entries so intake and the arithmetic pipe stall apart.
// ---------------------------------------------------------------------------
module qapm_queue
   import qapm_pkg::*;
#(
   parameter int ENTRY_W = entry_width(SAMPLE_WIDTH_DEF)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [ENTRY_W-1:0] wdata,
   input  logic               pop,
   output logic [ENTRY_W-1:0] rdata,
   output qapm_q_status_type  status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

   logic [ENTRY_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // pointer and level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata        = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL);

endmodule

// ===== rtl/qapm_back.sv =====
// ---------------------------------------------------------------------------
// qapm_back: PID arithmetic and X mixing pipeline
// Stage 1 gain products, stage 2 axis outputs, stage 3 motor sums with
// saturation into the response register. All stages move together.
// ---------------------------------------------------------------------------
module qapm_back
   import qapm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int GAIN_WIDTH   = GAIN_WIDTH_DEF,
   parameter int ENTRY_W      = entry_width(SAMPLE_WIDTH_DEF)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  qapm_q_status_type                    q_status,
   input  logic [ENTRY_W-1:0]                   q_rdata,
   output logic                                 q_pop,
   input  logic [NUM_AXES-1:0][GAIN_REG_W-1:0]  gains,
   input  logic [BASE_W-1:0]                    base_power,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [NUM_MOTORS-1:0][MOTOR_W-1:0]   rsp_motor
);

   localparam int EW   = SAMPLE_WIDTH + 1;
   localparam int GPW  = (3 * GAIN_WIDTH > GAIN_REG_W) ? 3 * GAIN_WIDTH : GAIN_REG_W;
   localparam int PEW  = GAIN_WIDTH + EW;
   localparam int PIW  = GAIN_WIDTH + INTEG_W;
   localparam int PDW  = GAIN_WIDTH + SAMPLE_WIDTH;
   localparam int AW   = ((PDW + 2 > PIW) ? PDW + 2 : PIW) + 2;
   localparam int MW   = ((AW > OUT_SHIFT + BASE_W + 1) ? AW : OUT_SHIFT + BASE_W + 1) + 3;
   localparam int SAT_LSB   = OUT_SHIFT + MOTOR_W;
   localparam int INT_BASE  = NUM_AXES * EW;
   localparam int RATE_BASE = INT_BASE + NUM_AXES * INTEG_W;

   // pipeline control
   logic advance;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;

   assign advance      = !out_valid_ff || !rsp_stall;
   assign q_pop        = advance && !q_status.empty;
   assign s1_valid_in  = advance ? !q_status.empty : s1_valid_ff;
   assign s2_valid_in  = advance ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = advance ? s2_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // stage 1: unpack gains and multiply
   logic [GPW-1:0]                greg   [NUM_AXES];
   logic signed [GAIN_WIDTH-1:0]  gp     [NUM_AXES];
   logic signed [GAIN_WIDTH-1:0]  gi     [NUM_AXES];
   logic signed [GAIN_WIDTH-1:0]  gd     [NUM_AXES];
   logic signed [EW-1:0]          err_h  [NUM_AXES];
   logic signed [INTEG_W-1:0]     int_h  [NUM_AXES];
   logic signed [SAMPLE_WIDTH-1:0] rate_h [NUM_AXES];
   logic signed [PEW-1:0] pe_ff [NUM_AXES], pe_in [NUM_AXES];
   logic signed [PIW-1:0] pi_ff [NUM_AXES], pi_in [NUM_AXES];
   logic signed [PDW-1:0] pd_ff [NUM_AXES], pd_in [NUM_AXES];

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         greg[a]   = GPW'(gains[a]);
         gp[a]     = signed'(greg[a][GAIN_WIDTH-1:0]);
         gi[a]     = signed'(greg[a][2*GAIN_WIDTH-1:GAIN_WIDTH]);
         gd[a]     = signed'(greg[a][3*GAIN_WIDTH-1:2*GAIN_WIDTH]);
         err_h[a]  = signed'(q_rdata[a*EW +: EW]);
         int_h[a]  = signed'(q_rdata[INT_BASE + a*INTEG_W +: INTEG_W]);
         rate_h[a] = signed'(q_rdata[RATE_BASE + a*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
         pe_in[a]  = PEW'(gp[a]) * PEW'(err_h[a]);
         pi_in[a]  = PIW'(gi[a]) * PIW'(int_h[a]);
         pd_in[a]  = PDW'(gd[a]) * PDW'(rate_h[a]);
      end
   end

   // stage 2: P*err + I*int - 4*D*rate at 2^-14 count
   logic signed [AW-1:0] ax_ff [NUM_AXES], ax_in [NUM_AXES];

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         ax_in[a] = AW'(pe_ff[a]) + AW'(pi_ff[a]) - (AW'(pd_ff[a]) <<< 2);
      end
   end

   // stage 3: X mix and saturate to 0..65535
   logic signed [MW-1:0]  base_s;
   logic signed [MW-1:0]  po, ro, yo;
   logic signed [MW-1:0]  msum [NUM_MOTORS];
   logic [MOTOR_W-1:0]    motor_ff [NUM_MOTORS], motor_in [NUM_MOTORS];

   always_comb begin
      base_s  = MW'(signed'({1'b0, base_power, {OUT_SHIFT{1'b0}}}));
      po      = MW'(ax_ff[0]);
      ro      = MW'(ax_ff[1]);
      yo      = MW'(ax_ff[2]);
      msum[0] = base_s + po + ro - yo;
      msum[1] = base_s - po + ro + yo;
      msum[2] = base_s - po - ro - yo;
      msum[3] = base_s + po - ro + yo;
      for (int m = 0; m < NUM_MOTORS; m++) begin
         if (msum[m][MW-1]) begin
            motor_in[m] = '0;
         end else if (|msum[m][MW-2:SAT_LSB]) begin
            motor_in[m] = '1;
         end else begin
            motor_in[m] = msum[m][SAT_LSB-1:OUT_SHIFT];
         end
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            pe_ff[a] <= pe_in[a];
            pi_ff[a] <= pi_in[a];
            pd_ff[a] <= pd_in[a];
            ax_ff[a] <= ax_in[a];
         end
         for (int m = 0; m < NUM_MOTORS; m++) begin
            motor_ff[m] <= motor_in[m];
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   always_comb begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
         rsp_motor[m] = motor_ff[m];
      end
   end

endmodule

// ===== rtl/qapm_checker.sv =====
// ---------------------------------------------------------------------------
// qapm_checker: port-level checks for the attitude PID mixer
// Tracks requests in flight and checks response rules at the ports.
// ---------------------------------------------------------------------------
module qapm_checker
   import qapm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [MOTOR_W-1:0] rsp_motor_one,
   input logic [MOTOR_W-1:0] rsp_motor_two,
   input logic [MOTOR_W-1:0] rsp_motor_three,
   input logic [MOTOR_W-1:0] rsp_motor_four
);

   localparam int MAX_FLIGHT = QUEUE_DEPTH + 3;
   localparam int FL_W       = $clog2(MAX_FLIGHT + 2);

   logic           req_take, rsp_take;
   logic [FL_W-1:0] flight_ff, flight_in;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // requests accepted but not yet answered
   always_comb begin
      case ({req_take, rsp_take})
         2'b10:   flight_in = flight_ff + 1'b1;
         2'b01:   flight_in = flight_ff - 1'b1;
         default: flight_in = flight_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flight_ff <= '0;
      end else begin
         flight_ff <= flight_in;
      end
   end

   // nothing pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response pending or intake stalled after reset");

   // every response belongs to an accepted request
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> flight_ff != '0)
      else $error("response without outstanding request");

   // queue plus pipe bound the work in flight
   a_flight_bound: assert property (@(posedge clock) disable iff (reset)
      flight_ff <= FL_W'(MAX_FLIGHT))
      else $error("too many requests in flight");

   // a stalled response holds its motor values
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_motor_one)
         && $stable(rsp_motor_two) && $stable(rsp_motor_three)
         && $stable(rsp_motor_four))
      else $error("stalled response changed");

endmodule

bind quad_attitude_pid_mixer_core qapm_checker u_qapm_checker (.*);
